// File: design/tpeq_pkg.sv
// Shared types and constants for the two-class priority event queue.
package tpeq_pkg;

    localparam int CAP_W      = 7;
    localparam int OCC_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE   = 1'b1;

    typedef enum logic [1:0] {
        REQ_PUSH    = 2'd0,
        REQ_PEEK    = 2'd1,
        REQ_POP     = 2'd2,
        REQ_POP_GET = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_INACTIVE = 2'd3
    } status_t;

    // Outcome of one request, carried to the response stage.
    typedef struct packed {
        status_t status;
        logic    has_data;
        logic    from_urgent;
    } dec_t;

    // Memory strobes for both queues.
    typedef struct packed {
        logic u_we;
        logic n_we;
        logic u_re;
        logic n_re;
    } mem_ctl_t;

endpackage

// File: design/tpeq_if.sv
// Channel interfaces: request, response and configuration write.
interface tpeq_req_if #(
    parameter int KIND_BITS    = 4,
    parameter int CHANNEL_BITS = 16
);
    logic                    valid;
    logic                    ready;
    logic [1:0]              req_type;
    logic                    urgent;
    logic [KIND_BITS-1:0]    event_kind;
    logic [CHANNEL_BITS-1:0] channel;

    modport source (output valid, req_type, urgent, event_kind, channel, input ready);
    modport sink   (input valid, req_type, urgent, event_kind, channel, output ready);
endinterface

interface tpeq_rsp_if #(
    parameter int KIND_BITS    = 4,
    parameter int CHANNEL_BITS = 16
);
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic [KIND_BITS-1:0]     out_kind;
    logic [CHANNEL_BITS-1:0]  out_channel;
    logic                     from_urgent;
    logic [tpeq_pkg::OCC_W-1:0] occupancy;

    modport source (output valid, status, out_kind, out_channel, from_urgent, occupancy,
                    input ready);
    modport sink   (input valid, status, out_kind, out_channel, from_urgent, occupancy,
                    output ready);
endinterface

interface tpeq_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tpeq_pkg::CFG_IDX_W-1:0]  index;
    logic [tpeq_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: design/two_class_priority_event_queue.sv
// Top level of the two-class strict-priority event queue.
//
//  port | dir  | moves                           | payload
//  -----+------+---------------------------------+-----------------------------------
//  req  | in   | one request per handshake       | req_type, urgent, event_kind, channel
//  rsp  | out  | one response per request        | status, out_kind, out_channel,
//       |      |                                 | from_urgent, occupancy
//  cfg  | in   | register write, always ready    | index (0 capacity, 1 active), data
//
// An accepted request is registered in the middle stage and then in the response
// register; one request is accepted per cycle while the response is not stalled.
// Reset clears pointers, counts and the peeked side; no memory clearing pass.
// A stalled response holds the middle stage, and req.ready drops only then.
module two_class_priority_event_queue #(
    parameter int DEPTH        = 64,
    parameter int CHANNEL_BITS = 16,
    parameter int KIND_BITS    = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    tpeq_req_if.sink  req,
    tpeq_rsp_if.source rsp,
    tpeq_cfg_if.sink  cfg
);
    import tpeq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int DW = KIND_BITS + CHANNEL_BITS;

    // Configuration registers.
    logic [CAP_W-1:0] cap_reg;
    logic             active_reg;

    // Middle stage: decision waiting for memory read data.
    logic             s1_valid_reg;
    dec_t             s1_dec_reg;
    logic [OCC_W-1:0] s1_occ_reg;

    // Response register.
    logic                    out_valid_reg;
    status_t                 out_status_reg;
    logic [KIND_BITS-1:0]    out_kind_reg;
    logic [CHANNEL_BITS-1:0] out_chan_reg;
    logic                    out_urg_reg;
    logic [OCC_W-1:0]        out_occ_reg;

    logic             fire;
    logic             out_free;
    mem_ctl_t         mem_ctl;
    dec_t             dec;
    logic [OCC_W-1:0] occ_next;
    logic [AW-1:0]    u_waddr, n_waddr, u_raddr, n_raddr;
    logic [DW-1:0]    wdata, u_rdata, n_rdata, sel_rdata;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || out_free;
    assign fire      = req.valid && req.ready;
    assign cfg.ready = 1'b1;
    assign wdata     = {req.event_kind, req.channel};

    tpeq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .req_type (req.req_type),
        .urgent   (req.urgent),
        .capacity (cap_reg),
        .active   (active_reg),
        .mem_ctl  (mem_ctl),
        .u_waddr  (u_waddr),
        .n_waddr  (n_waddr),
        .u_raddr  (u_raddr),
        .n_raddr  (n_raddr),
        .dec      (dec),
        .occ_next (occ_next)
    );

    // One push or one head read per request, so a write and a read never
    // meet on one entry in the same cycle.
    tpeq_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_urgent_ram (
        .clk   (clk),
        .we    (mem_ctl.u_we),
        .waddr (u_waddr),
        .wdata (wdata),
        .re    (mem_ctl.u_re),
        .raddr (u_raddr),
        .rdata (u_rdata)
    );

    tpeq_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_normal_ram (
        .clk   (clk),
        .we    (mem_ctl.n_we),
        .waddr (n_waddr),
        .wdata (wdata),
        .re    (mem_ctl.n_re),
        .raddr (n_raddr),
        .rdata (n_rdata)
    );

    assign sel_rdata = s1_dec_reg.from_urgent ? u_rdata : n_rdata;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= CAP_RESET;
            active_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_CAPACITY: cap_reg    <= cfg.data[CAP_W-1:0];
                CFG_ACTIVE:   active_reg <= cfg.data[0];
                default:      active_reg <= active_reg;
            endcase
        end
    end

    // Middle stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_dec_reg <= dec;
            s1_occ_reg <= occ_next;
        end
    end

    // Response register; read data is picked up while it sits on the RAM output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            out_status_reg <= s1_dec_reg.status;
            out_urg_reg    <= s1_dec_reg.has_data && s1_dec_reg.from_urgent;
            out_occ_reg    <= s1_occ_reg;
            if (s1_dec_reg.has_data)
            begin
                out_kind_reg <= sel_rdata[DW-1:CHANNEL_BITS];
                out_chan_reg <= sel_rdata[CHANNEL_BITS-1:0];
            end
            else
            begin
                out_kind_reg <= '0;
                out_chan_reg <= '0;
            end
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.out_kind    = out_kind_reg;
    assign rsp.out_channel = out_chan_reg;
    assign rsp.from_urgent = out_urg_reg;
    assign rsp.occupancy   = out_occ_reg;

`ifndef SYNTHESIS
    a_rdata_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_dec_reg.has_data && !out_free) |=> $stable(sel_rdata))
        else $error("read data changed under a stalled request");

    a_no_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |->
            (rsp.out_kind == '0 && rsp.out_channel == '0 && !rsp.from_urgent))
        else $error("failed request returned event data");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_free) |=> out_valid_reg)
        else $error("middle stage lost a request");

    a_rsp_held: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=>
            (rsp.valid && $stable(rsp.status) && $stable(rsp.out_kind) &&
             $stable(rsp.out_channel) && $stable(rsp.from_urgent) &&
             $stable(rsp.occupancy)))
        else $error("stalled response changed");
`endif

endmodule

// File: design/tpeq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tpeq_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/tpeq_ctrl.sv
// Queue pointers, counts and per-request decision.
module tpeq_ctrl #(
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     fire,
    input  logic [1:0]               req_type,
    input  logic                     urgent,
    input  logic [tpeq_pkg::CAP_W-1:0] capacity,
    input  logic                     active,
    output tpeq_pkg::mem_ctl_t       mem_ctl,
    output logic [$clog2(DEPTH)-1:0] u_waddr,
    output logic [$clog2(DEPTH)-1:0] n_waddr,
    output logic [$clog2(DEPTH)-1:0] u_raddr,
    output logic [$clog2(DEPTH)-1:0] n_raddr,
    output tpeq_pkg::dec_t           dec,
    output logic [tpeq_pkg::OCC_W-1:0] occ_next
);
    import tpeq_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [AW-1:0]    u_head_reg, u_head_next, u_tail_reg, u_tail_next;
    logic [AW-1:0]    n_head_reg, n_head_next, n_tail_reg, n_tail_next;
    logic [CNT_W-1:0] u_cnt_reg, u_cnt_next, n_cnt_reg, n_cnt_next;
    logic             peek_u_reg, peek_u_next;
    logic [CNT_W-1:0] total, total_next;
    logic [LIM_W-1:0] cap_ext, limit;
    logic             full;
    logic             from_u;

    function automatic logic [AW-1:0] advance(input logic [AW-1:0] idx);
        return (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
    endfunction

    // Both counts together never exceed DEPTH, so the sum fits.
    assign total   = u_cnt_reg + n_cnt_reg;
    assign cap_ext = LIM_W'(capacity);
    assign limit   = (cap_ext > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : cap_ext;
    assign full    = LIM_W'(total) >= limit;
    assign from_u  = u_cnt_reg != '0;

    assign u_waddr = u_tail_reg;
    assign n_waddr = n_tail_reg;
    assign u_raddr = u_head_reg;
    assign n_raddr = n_head_reg;

    always_comb
    begin
        u_head_next = u_head_reg;
        u_tail_next = u_tail_reg;
        u_cnt_next  = u_cnt_reg;
        n_head_next = n_head_reg;
        n_tail_next = n_tail_reg;
        n_cnt_next  = n_cnt_reg;
        peek_u_next = peek_u_reg;
        dec         = '{status: ST_OK, has_data: 1'b0, from_urgent: 1'b0};
        mem_ctl     = '0;
        case (req_t'(req_type))
            REQ_PUSH:
            begin
                if (!active)
                begin
                    dec.status = ST_INACTIVE;
                end
                else if (full)
                begin
                    dec.status = ST_FULL;
                end
                else if (urgent)
                begin
                    mem_ctl.u_we = fire;
                    u_tail_next  = advance(u_tail_reg);
                    u_cnt_next   = u_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    mem_ctl.n_we = fire;
                    n_tail_next  = advance(n_tail_reg);
                    n_cnt_next   = n_cnt_reg + CNT_W'(1);
                end
            end
            REQ_POP:
            begin
                // Plain pop ignores the active flag.
                if (peek_u_reg)
                begin
                    if (u_cnt_reg == '0)
                    begin
                        dec.status = ST_EMPTY;
                    end
                    else
                    begin
                        u_head_next = advance(u_head_reg);
                        u_cnt_next  = u_cnt_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    if (n_cnt_reg == '0)
                    begin
                        dec.status = ST_EMPTY;
                    end
                    else
                    begin
                        n_head_next = advance(n_head_reg);
                        n_cnt_next  = n_cnt_reg - CNT_W'(1);
                    end
                end
            end
            REQ_PEEK, REQ_POP_GET:
            begin
                if (!active)
                begin
                    dec.status = ST_INACTIVE;
                end
                else if (total == '0)
                begin
                    dec.status = ST_EMPTY;
                end
                else
                begin
                    dec.has_data    = 1'b1;
                    dec.from_urgent = from_u;
                    mem_ctl.u_re    = fire && from_u;
                    mem_ctl.n_re    = fire && !from_u;
                    if (req_t'(req_type) == REQ_PEEK)
                    begin
                        peek_u_next = from_u;
                    end
                    else if (from_u)
                    begin
                        u_head_next = advance(u_head_reg);
                        u_cnt_next  = u_cnt_reg - CNT_W'(1);
                    end
                    else
                    begin
                        n_head_next = advance(n_head_reg);
                        n_cnt_next  = n_cnt_reg - CNT_W'(1);
                    end
                end
            end
            default:
            begin
                dec.status = ST_OK;
            end
        endcase
    end

    assign total_next = u_cnt_next + n_cnt_next;
    assign occ_next   = OCC_W'(total_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_head_reg <= '0;
            u_tail_reg <= '0;
            u_cnt_reg  <= '0;
            n_head_reg <= '0;
            n_tail_reg <= '0;
            n_cnt_reg  <= '0;
            peek_u_reg <= 1'b0;
        end
        else if (fire)
        begin
            u_head_reg <= u_head_next;
            u_tail_reg <= u_tail_next;
            u_cnt_reg  <= u_cnt_next;
            n_head_reg <= n_head_next;
            n_tail_reg <= n_tail_next;
            n_cnt_reg  <= n_cnt_next;
            peek_u_reg <= peek_u_next;
        end
    end

`ifndef SYNTHESIS
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(u_cnt_reg) + 32'(n_cnt_reg)) <= DEPTH)
        else $error("queues hold more than DEPTH events");

    a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({mem_ctl.u_we, mem_ctl.n_we, mem_ctl.u_re, mem_ctl.n_re}))
        else $error("more than one memory access for one request");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.u_we |=> u_cnt_reg == $past(u_cnt_reg) + CNT_W'(1))
        else $error("urgent push did not bump the count");

    a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_ctl.u_re |-> u_cnt_reg != '0) and (mem_ctl.n_re |-> n_cnt_reg != '0))
        else $error("head read from an empty queue");
`endif

endmodule
